[rtl/core/ple_pkg.sv]
package ple_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SET    = 3'd3,
    OP_GET    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              wr;
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

[rtl/core/ple_cell.sv]
module ple_cell
  import ple_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic [DATA_W-1:0] prev_q,
  input  logic [DATA_W-1:0] next_q,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (cmd.wr && (cell_index == cmd.pos)) begin
      q_nxt = cmd.value;
    end else if (cmd.ins && (cell_index > cmd.pos)) begin
      q_nxt = prev_q;
    end else if (cmd.rem && (cell_index >= cmd.pos)) begin
      q_nxt = next_q;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

[rtl/core/ple_chain.sv]
module ple_chain
  import ple_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  output logic [DATA_W-1:0] cell_q [DEPTH]
);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] prev_q;
      logic [DATA_W-1:0] next_q;

      if (i == 0) begin : g_first
        assign prev_q = '0;
      end else begin : g_prev
        assign prev_q = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign next_q = '0;
      end else begin : g_next
        assign next_q = cell_q[i+1];
      end

      ple_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .cell_index(IDX_W'(i)),
        .prev_q    (prev_q),
        .next_q    (next_q),
        .q         (cell_q[i])
      );
    end
  endgenerate

endmodule

[rtl/core/positional_list_engine.sv]
// Channel   Ports                                        Handshake
// input     in_operation, in_position, in_item_value     start && !busy
// result    out_read_value, out_entry_count, out_status  out_valid, one cycle
//
// One item is taken in every cycle; busy is never raised.
// The result of an item appears in the cycle after it is accepted.
// Inserts and removes shift the entries from the given position onward at once through the row of cells.
// Reset clears the count; entry contents are undefined until written.
// The receiver cannot stall, so results are never held back.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_operation,
  input  logic [4:0]        in_position,
  input  logic [DATA_W-1:0] in_item_value,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_read_value,
  output logic [4:0]        out_entry_count,
  output logic [1:0]        out_status
);

  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [DATA_W-1:0] read_nxt;
  logic [4:0]        out_entry_count_r;
  status_t           out_status_r;
  status_t           status_nxt;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_q [DEPTH];
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  cnt_nxt_w;
  logic              full;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_w  = CMP_W'(in_position);
  assign cnt_w  = CMP_W'(cnt_r);
  assign full   = (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_DONE;
    read_nxt   = '0;
    cmd.wr     = 1'b0;
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.pos    = pos_w[IDX_W-1:0];
    cmd.value  = in_item_value;
    if (accept) begin
      unique case (op_t'(in_operation))
        OP_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.wr  = 1'b1;
            cmd.pos = cnt_w[IDX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (pos_w > cnt_w) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.wr  = 1'b1;
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            cmd.rem = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        OP_SET: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
        OP_GET: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            read_nxt = cell_q[pos_w[IDX_W-1:0]];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_nxt_w = CMP_W'(cnt_nxt);

  ple_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .cell_q(cell_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
    out_read_value_r  <= read_nxt;
    out_entry_count_r <= cnt_nxt_w[4:0];
    out_status_r      <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_status      = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an accepted item");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (cnt_r == CNT_W'(DEPTH)))
    else $error("full status while list is not full");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != '0)) |-> (out_status == ST_DONE))
    else $error("read value returned with an error status");

endmodule

[verif/positional_list_engine_tb.sv]
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 490;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [4:0]        entry_count;
    logic [1:0]        status;
  } list_result_t;

  // Mirrors the list contents and holds the results still owed by the block.
  class list_scoreboard;
    logic [DATA_W-1:0] entries [DEPTH];
    int unsigned       held;
    list_result_t      owed [$];
    int                errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_item(logic [2:0] op, logic [4:0] pos, logic [DATA_W-1:0] val);
      list_result_t res;
      int unsigned  i;
      res.read_value = '0;
      res.status = ST_DONE;
      case (op)
        OP_APPEND: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            entries[held] = val;
            held++;
          end
        end
        OP_INSERT: begin
          if (pos > held) begin
            res.status = ST_RANGE;
          end else if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (i = held; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            held++;
          end
        end
        OP_REMOVE: begin
          if (pos >= held) begin
            res.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < held; i++) entries[i] = entries[i+1];
            held--;
          end
        end
        OP_SET: begin
          if (pos >= held) res.status = ST_RANGE;
          else entries[pos] = val;
        end
        OP_GET: begin
          if (pos >= held) res.status = ST_RANGE;
          else res.read_value = entries[pos];
        end
        default: begin
        end
      endcase
      res.entry_count = held[4:0];
      owed.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] rd, logic [4:0] cnt, logic [1:0] st);
      list_result_t exp_res;
      if (owed.size() == 0) begin
        $error("unexpected result: read_value %0h entry_count %0d status %0d", rd, cnt, st);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (rd !== exp_res.read_value) begin
        $error("read_value: expected %0h, actual %0h", exp_res.read_value, rd);
        errors++;
      end
      if (cnt !== exp_res.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp_res.entry_count, cnt);
        errors++;
      end
      if (st !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, st);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_operation = '0;
  logic [4:0]        in_position = '0;
  logic [DATA_W-1:0] in_item_value = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_value;
  logic [4:0]        out_entry_count;
  logic [1:0]        out_status;

  list_scoreboard sb = new();
  int             idle_pct = 0;
  int             cycle_count = 0;

  positional_list_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_list_engine_tb: FAIL");
      $finish;
    end
  end

  // Results are checked before the item accepted at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_read_value, out_entry_count, out_status);
      if (start && !busy) sb.note_item(in_operation, in_position, in_item_value);
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [4:0] pos,
                           input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_position <= pos;
    in_item_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(7) != 0) return $urandom();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Switches at random between growing and shrinking stretches so that both the
  // empty and the full list are visited often.
  task automatic run_phase(input int n_items, input int pct);
    int         k;
    int         r;
    bit         grow;
    logic [2:0] op;
    logic [4:0] pos;
    idle_pct = pct;
    grow = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) grow = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (grow) begin
        if (r < 35) op = OP_APPEND;
        else if (r < 63) op = OP_INSERT;
        else if (r < 73) op = OP_REMOVE;
        else if (r < 83) op = OP_SET;
        else if (r < 97) op = OP_GET;
        else op = 3'($urandom_range(7, 5));
      end else begin
        if (r < 10) op = OP_APPEND;
        else if (r < 20) op = OP_INSERT;
        else if (r < 62) op = OP_REMOVE;
        else if (r < 75) op = OP_SET;
        else if (r < 97) op = OP_GET;
        else op = 3'($urandom_range(7, 5));
      end
      if ($urandom_range(99) < 85) pos = 5'($urandom_range(sb.held, 0));
      else pos = 5'($urandom_range(31, 0));
      send_item(op, pos, pick_value());
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Operations on an empty list, and the unused operation codes.
    send_item(OP_GET, 5'd0, 32'h1234_5678);
    send_item(OP_REMOVE, 5'd0, 32'h0);
    send_item(OP_SET, 5'd0, 32'hDEAD_BEEF);
    send_item(OP_INSERT, 5'd1, 32'h5);
    for (k = 5; k <= 7; k++) send_item(k[2:0], 5'd31, 32'hFFFF_FFFF);

    // Extreme values, and a stored -1 read back as a plain value.
    send_item(OP_INSERT, 5'd0, 32'h8000_0000);
    send_item(OP_APPEND, 5'd0, 32'h7FFF_FFFF);
    send_item(OP_APPEND, 5'd31, 32'hFFFF_FFFF);
    send_item(OP_GET, 5'd2, 32'h0);
    send_item(OP_INSERT, 5'd3, 32'h0);

    // Fill the list, then hit the full and out-of-range checks on insert.
    repeat (DEPTH - 4) send_item(OP_APPEND, 5'd0, $urandom());
    send_item(OP_APPEND, 5'd0, 32'h1);
    send_item(OP_INSERT, 5'd16, 32'h2);
    send_item(OP_INSERT, 5'd17, 32'h3);
    send_item(OP_REMOVE, 5'd0, 32'h0);
    send_item(OP_REMOVE, 5'd14, 32'h0);
    send_item(OP_GET, 5'd15, 32'h0);
    drain();

    run_phase(ITEMS_PER_PHASE, 0);
    drain();
    run_phase(ITEMS_PER_PHASE, 53);
    drain();
    run_phase(ITEMS_PER_PHASE, 26);
    run_phase(ITEMS_PER_PHASE, 0);
    drain();
    repeat (5) @(posedge clk);

    if (sb.errors == 0) begin
      $display("positional_list_engine_tb: PASS");
    end else begin
      $display("positional_list_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
